/* design/essgi_pkg.sv */
// Package for the energy source selector with gas ignition sequencer.
// Holds source and phase codes, register indexes, timing constants and reset values.
// Depends on nothing; used by energy_source_select_gas_ignition.
`default_nettype none

package essgi_pkg;

  // Width of a configuration register index on the write port.
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SOLAR_UV      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESTART      = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARK_CHECK   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IGN_WINDOW    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FAULT_RETRY   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAS_INHIBIT   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BEEP_PERIOD   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BEEP_PULSES   = 4'd7;

  // Reset values of the configuration registers.
  localparam logic [9:0]  RST_SOLAR_UV    = 10'd512;
  localparam logic [30:0] RST_PRESTART    = 31'd2000;
  localparam logic [30:0] RST_SPARK_CHECK = 31'd3000;
  localparam logic [30:0] RST_IGN_WINDOW  = 31'd30000;
  localparam logic [30:0] RST_FAULT_RETRY = 31'd600000;
  localparam logic [30:0] RST_GAS_INHIBIT = 31'd900000;
  localparam logic [30:0] RST_BEEP_PERIOD = 31'd60000;
  localparam logic [3:0]  RST_BEEP_PULSES = 4'd3;

  // Energy source codes.
  localparam logic [1:0] MODE_AC    = 2'd0;
  localparam logic [1:0] MODE_DC12  = 2'd1;
  localparam logic [1:0] MODE_SOLAR = 2'd2;
  localparam logic [1:0] MODE_GAS   = 2'd3;

  // Gas sequencer phase codes.
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_PRESTART = 3'd1;
  localparam logic [2:0] PH_SPARK    = 3'd2;
  localparam logic [2:0] PH_WINDOW   = 3'd3;
  localparam logic [2:0] PH_RUN      = 3'd4;
  localparam logic [2:0] PH_FAULT    = 3'd5;

  // Fixed timing and count constants.
  localparam logic [31:0] PULSE_GAP_MS     = 32'd500;
  localparam logic [4:0]  PULSE_FAIL_LIMIT = 5'd28;
  localparam logic [4:0]  PULSE_SAT        = 5'd31;
  localparam logic [3:0]  NOSPARK_BEEPS    = 4'd3;
  localparam logic [3:0]  NOIGNITE_BEEPS   = 4'd5;

  // Division by 1000 ms as a multiply by ceil(2^38 / 1000); exact for any 32-bit value.
  localparam logic [63:0] BLINK_RECIP     = 64'd274877907;
  localparam int unsigned BLINK_SHIFT     = 38;

endpackage

`default_nettype wire

/* design/energy_source_select_gas_ignition.sv */
// Energy source selector and gas ignition sequencer, top level.
// Depends on essgi_pkg for codes, register indexes and constants.
// Usage:
//   Each input word is one control tick: ADC readings, source presence flags,
//   spark feedback and a millisecond timestamp. Each tick yields exactly one
//   result word with the heater, gas and LED drives, pulse and beep requests,
//   the selected source and the gas phase.
//   Channels use valid/ready. A tick is captured into an input register, then
//   evaluated combinationally against the controller state; the state and the
//   result register update together. The result word passes the input register
//   and then the result register (two register stages); one tick is taken every
//   cycle while out_ready keeps up, limited by the single compare-and-update path.
//   The timestamp is divided by 1000 for the inhibit blink with a reciprocal
//   multiply at the input register.
//   When the receiver stalls, the result register holds and the input
//   register fills; in_ready drops only when both are occupied and out_ready
//   is low. Configuration writes go through the cfg_ channel, always ready; the
//   user must make them only while no tick is in flight, which the block does
//   not enforce. Other indexes are ignored. Synchronous active-low reset loads
//   the register defaults, selects gas, idles the sequencer, clears drive latches.
`default_nettype none

module energy_source_select_gas_ignition (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // Input channel
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire  [9:0]                           in_temp_level,
  input  wire  [9:0]                           in_setpoint_level,
  input  wire  [9:0]                           in_battery_level,
  input  wire                                  in_mains_present,
  input  wire                                  in_engine_running,
  input  wire                                  in_solar_active,
  input  wire                                  in_spark_present,
  input  wire  [31:0]                          in_now_ms,
  // Result channel
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic                                 out_ac_heater_on,
  output logic                                 out_dc_heater_on,
  output logic                                 out_gas_ignite_on,
  output logic                                 out_led_on,
  output logic [1:0]                           out_pulse_requests,
  output logic [3:0]                           out_beep_count,
  output logic [1:0]                           out_source_mode,
  output logic [2:0]                           out_gas_phase,
  // Configuration channel
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [essgi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [essgi_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import essgi_pkg::*;

  // Configuration registers
  logic [9:0]  solar_uv_r;
  logic [30:0] prestart_r, spark_check_r, ign_window_r, fault_retry_r;
  logic [30:0] gas_inhibit_r, beep_period_r;
  logic [3:0]  beep_pulses_r;

  // Input register stage
  logic        s1_valid_r;
  logic [9:0]  s1_temp_r, s1_setp_r, s1_batt_r;
  logic        s1_mains_r, s1_engine_r, s1_solar_r, s1_spark_r, s1_blink_r;
  logic [31:0] s1_now_r;
  logic [63:0] blink_prod;
  logic        advance;

  // Controller state
  logic [1:0]  mode_r, mode_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic [31:0] start_r, start_nxt;
  logic [31:0] fault_end_r, fault_end_nxt;
  logic [31:0] inh_end_r, inh_end_nxt;
  logic        inh_act_r, inh_act_nxt;
  logic [4:0]  pulses_r, pulses_nxt;
  logic        spark_hit_r, spark_hit_nxt;
  logic [31:0] last_beep_r, last_beep_nxt;
  logic        beep_v_r, beep_v_nxt;
  logic [31:0] last_pulse_r, last_pulse_nxt;
  logic        pulse_v_r, pulse_v_nxt;
  logic        lat_ac_r, lat_ac_nxt, lat_dc_r, lat_dc_nxt;
  logic        lat_gas_r, lat_gas_nxt, lat_led_r, lat_led_nxt;

  // Per-tick request counts and helpers
  logic [1:0]  n_pulse;
  logic [3:0]  n_beep;
  logic        need, stop;
  logic [31:0] elapsed, inh_diff, fault_diff;

  // Result register
  logic        out_valid_r;
  logic        o_ac_r, o_dc_r, o_gas_r, o_led_r;
  logic [1:0]  o_pulse_r, o_mode_r;
  logic [3:0]  o_beep_r;
  logic [2:0]  o_phase_r;

  // Handshake control: the evaluation stage moves whenever the result slot is free.
  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  // Configuration writes; unused indexes fall through.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      solar_uv_r    <= RST_SOLAR_UV;
      prestart_r    <= RST_PRESTART;
      spark_check_r <= RST_SPARK_CHECK;
      ign_window_r  <= RST_IGN_WINDOW;
      fault_retry_r <= RST_FAULT_RETRY;
      gas_inhibit_r <= RST_GAS_INHIBIT;
      beep_period_r <= RST_BEEP_PERIOD;
      beep_pulses_r <= RST_BEEP_PULSES;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SOLAR_UV:    solar_uv_r    <= cfg_data[9:0];
        REG_PRESTART:    prestart_r    <= cfg_data[30:0];
        REG_SPARK_CHECK: spark_check_r <= cfg_data[30:0];
        REG_IGN_WINDOW:  ign_window_r  <= cfg_data[30:0];
        REG_FAULT_RETRY: fault_retry_r <= cfg_data[30:0];
        REG_GAS_INHIBIT: gas_inhibit_r <= cfg_data[30:0];
        REG_BEEP_PERIOD: beep_period_r <= cfg_data[30:0];
        REG_BEEP_PULSES: beep_pulses_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Bit 0 of now / 1000, taken from the reciprocal product.
  assign blink_prod = {32'd0, in_now_ms} * BLINK_RECIP;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_temp_r   <= in_temp_level;
      s1_setp_r   <= in_setpoint_level;
      s1_batt_r   <= in_battery_level;
      s1_mains_r  <= in_mains_present;
      s1_engine_r <= in_engine_running;
      s1_solar_r  <= in_solar_active;
      s1_spark_r  <= in_spark_present;
      s1_now_r    <= in_now_ms;
      s1_blink_r  <= blink_prod[BLINK_SHIFT];
    end
  end

  // Demand compares, and time differences against the stored marks.
  assign need       = s1_temp_r < s1_setp_r;
  assign stop       = s1_temp_r > s1_setp_r;
  assign elapsed    = s1_now_r - start_r;
  assign fault_diff = s1_now_r - fault_end_r;

  // Tick evaluation: source choice, heaters and the gas sequencer.
  always_comb begin
    mode_nxt       = mode_r;
    phase_nxt      = phase_r;
    start_nxt      = start_r;
    fault_end_nxt  = fault_end_r;
    inh_end_nxt    = inh_end_r;
    inh_act_nxt    = inh_act_r;
    pulses_nxt     = pulses_r;
    spark_hit_nxt  = spark_hit_r;
    last_beep_nxt  = last_beep_r;
    beep_v_nxt     = beep_v_r;
    last_pulse_nxt = last_pulse_r;
    pulse_v_nxt    = pulse_v_r;
    lat_ac_nxt     = lat_ac_r;
    lat_dc_nxt     = lat_dc_r;
    lat_gas_nxt    = lat_gas_r;
    lat_led_nxt    = lat_led_r;
    n_pulse        = 2'd0;
    n_beep         = 4'd0;
    inh_diff       = 32'd0;

    // Priority source choice.
    priority if (s1_mains_r) begin
      mode_nxt = MODE_AC;
    end else if (s1_engine_r) begin
      mode_nxt = MODE_DC12;
    end else if (s1_solar_r && (s1_batt_r > solar_uv_r)) begin
      mode_nxt = MODE_SOLAR;
    end else begin
      mode_nxt = MODE_GAS;
    end

    // A source change makes every drive safe.
    if (mode_nxt != mode_r) begin
      lat_ac_nxt  = 1'b0;
      lat_dc_nxt  = 1'b0;
      lat_gas_nxt = 1'b0;
      lat_led_nxt = 1'b0;
      if ((mode_r == MODE_DC12) && (mode_nxt == MODE_GAS)) begin
        inh_end_nxt = s1_now_r + {1'b0, gas_inhibit_r};
        inh_act_nxt = 1'b1;
      end
      if (mode_nxt != MODE_GAS) begin
        phase_nxt     = PH_IDLE;
        start_nxt     = s1_now_r;
        spark_hit_nxt = 1'b0;
        pulses_nxt    = 5'd0;
      end
    end

    unique case (mode_nxt)
      MODE_AC: begin
        lat_gas_nxt = 1'b0;
        lat_dc_nxt  = 1'b0;
        if (need) begin
          lat_ac_nxt  = 1'b1;
          lat_led_nxt = 1'b1;
        end else if (stop) begin
          lat_ac_nxt  = 1'b0;
          lat_led_nxt = 1'b0;
        end
      end
      MODE_DC12: begin
        lat_gas_nxt = 1'b0;
        lat_ac_nxt  = 1'b0;
        if (need) begin
          lat_dc_nxt  = 1'b1;
          lat_led_nxt = 1'b1;
        end else if (stop) begin
          lat_dc_nxt  = 1'b0;
          lat_led_nxt = 1'b0;
        end
      end
      MODE_SOLAR: begin
        lat_gas_nxt = 1'b0;
        lat_ac_nxt  = 1'b0;
        if (s1_batt_r <= solar_uv_r) begin
          lat_dc_nxt  = 1'b0;
          lat_led_nxt = 1'b0;
        end else if (need) begin
          lat_dc_nxt  = 1'b1;
          lat_led_nxt = 1'b1;
        end else if (stop) begin
          lat_dc_nxt  = 1'b0;
          lat_led_nxt = 1'b0;
        end
      end
      MODE_GAS: begin
        lat_ac_nxt = 1'b0;
        lat_dc_nxt = 1'b0;
        inh_diff   = s1_now_r - inh_end_nxt;
        if (s1_mains_r || s1_engine_r || !need) begin
          // Lost demand or a better source: abort to idle.
          lat_gas_nxt = 1'b0;
          phase_nxt   = PH_IDLE;
          start_nxt   = s1_now_r;
        end else if (inh_act_nxt && inh_diff[31]) begin
          // Gas still blocked after leaving 12 V: blink and keep gas off.
          lat_led_nxt = s1_blink_r;
          lat_gas_nxt = 1'b0;
        end else begin
          inh_act_nxt = 1'b0;
          unique case (phase_r)
            PH_IDLE: begin
              phase_nxt = PH_PRESTART;
              start_nxt = s1_now_r;
            end
            PH_PRESTART: begin
              lat_led_nxt = 1'b0;
              lat_gas_nxt = 1'b0;
              if (elapsed >= {1'b0, prestart_r}) begin
                spark_hit_nxt = 1'b0;
                lat_gas_nxt   = 1'b1;
                phase_nxt     = PH_SPARK;
                start_nxt     = s1_now_r;
              end
            end
            PH_SPARK: begin
              lat_led_nxt = 1'b1;
              lat_gas_nxt = 1'b1;
              if (s1_spark_r) begin
                spark_hit_nxt = 1'b1;
              end
              if (elapsed >= {1'b0, spark_check_r}) begin
                if (!spark_hit_nxt) begin
                  lat_gas_nxt   = 1'b0;
                  n_pulse       = 2'd1;
                  n_beep        = NOSPARK_BEEPS;
                  fault_end_nxt = s1_now_r + {1'b0, fault_retry_r};
                  beep_v_nxt    = 1'b0;
                  pulse_v_nxt   = 1'b0;
                  phase_nxt     = PH_FAULT;
                  start_nxt     = s1_now_r;
                end else begin
                  pulses_nxt = 5'd0;
                  phase_nxt  = PH_WINDOW;
                  start_nxt  = s1_now_r;
                end
              end
            end
            PH_WINDOW: begin
              lat_led_nxt = 1'b1;
              lat_gas_nxt = 1'b1;
              if (s1_spark_r && (pulses_r < PULSE_SAT)) begin
                pulses_nxt = pulses_r + 5'd1;
              end
              if (elapsed >= {1'b0, ign_window_r}) begin
                if (pulses_nxt >= PULSE_FAIL_LIMIT) begin
                  lat_gas_nxt   = 1'b0;
                  n_pulse       = 2'd2;
                  n_beep        = NOIGNITE_BEEPS;
                  fault_end_nxt = s1_now_r + {1'b0, fault_retry_r};
                  beep_v_nxt    = 1'b0;
                  pulse_v_nxt   = 1'b0;
                  phase_nxt     = PH_FAULT;
                  start_nxt     = s1_now_r;
                end else begin
                  phase_nxt = PH_RUN;
                  start_nxt = s1_now_r;
                end
              end
            end
            PH_RUN: begin
              lat_led_nxt = 1'b1;
              lat_gas_nxt = 1'b0;
              if (s1_spark_r) begin
                pulses_nxt = 5'd0;
                phase_nxt  = PH_WINDOW;
                start_nxt  = s1_now_r;
              end else if (stop) begin
                phase_nxt = PH_IDLE;
                start_nxt = s1_now_r;
              end
            end
            PH_FAULT: begin
              lat_gas_nxt = 1'b0;
              // Periodic pulse and beep requests while waiting to retry.
              if (!pulse_v_r || ((s1_now_r - last_pulse_r) >= PULSE_GAP_MS)) begin
                n_pulse        = 2'd1;
                last_pulse_nxt = s1_now_r;
                pulse_v_nxt    = 1'b1;
              end
              if (!beep_v_r || ((s1_now_r - last_beep_r) >= {1'b0, beep_period_r})) begin
                n_beep        = beep_pulses_r;
                last_beep_nxt = s1_now_r;
                beep_v_nxt    = 1'b1;
              end
              if (!fault_diff[31]) begin
                beep_v_nxt  = 1'b0;
                pulse_v_nxt = 1'b0;
                phase_nxt   = PH_PRESTART;
                start_nxt   = s1_now_r;
              end
            end
            default: begin
              // Unused phase code: gas off, back to idle.
              lat_gas_nxt = 1'b0;
              phase_nxt   = PH_IDLE;
              start_nxt   = s1_now_r;
            end
          endcase
        end
      end
    endcase
  end

  // Controller state updates once per evaluated tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_GAS;
      phase_r      <= PH_IDLE;
      start_r      <= 32'd0;
      fault_end_r  <= 32'd0;
      inh_end_r    <= 32'd0;
      inh_act_r    <= 1'b0;
      pulses_r     <= 5'd0;
      spark_hit_r  <= 1'b0;
      last_beep_r  <= 32'd0;
      beep_v_r     <= 1'b0;
      last_pulse_r <= 32'd0;
      pulse_v_r    <= 1'b0;
      lat_ac_r     <= 1'b0;
      lat_dc_r     <= 1'b0;
      lat_gas_r    <= 1'b0;
      lat_led_r    <= 1'b0;
    end else if (s1_valid_r && advance) begin
      mode_r       <= mode_nxt;
      phase_r      <= phase_nxt;
      start_r      <= start_nxt;
      fault_end_r  <= fault_end_nxt;
      inh_end_r    <= inh_end_nxt;
      inh_act_r    <= inh_act_nxt;
      pulses_r     <= pulses_nxt;
      spark_hit_r  <= spark_hit_nxt;
      last_beep_r  <= last_beep_nxt;
      beep_v_r     <= beep_v_nxt;
      last_pulse_r <= last_pulse_nxt;
      pulse_v_r    <= pulse_v_nxt;
      lat_ac_r     <= lat_ac_nxt;
      lat_dc_r     <= lat_dc_nxt;
      lat_gas_r    <= lat_gas_nxt;
      lat_led_r    <= lat_led_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && advance) begin
      o_ac_r    <= lat_ac_nxt;
      o_dc_r    <= lat_dc_nxt;
      o_gas_r   <= lat_gas_nxt;
      o_led_r   <= lat_led_nxt;
      o_pulse_r <= n_pulse;
      o_beep_r  <= n_beep;
      o_mode_r  <= mode_nxt;
      o_phase_r <= phase_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_ac_heater_on   = o_ac_r;
  assign out_dc_heater_on   = o_dc_r;
  assign out_gas_ignite_on  = o_gas_r;
  assign out_led_on         = o_led_r;
  assign out_pulse_requests = o_pulse_r;
  assign out_beep_count     = o_beep_r;
  assign out_source_mode    = o_mode_r;
  assign out_gas_phase      = o_phase_r;

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// Testbench for energy_source_select_gas_ignition: source priority, heater hold band,
// gas ignition sequencing and fault alarms, checked word by word against a local predictor.
// Depends on essgi_pkg and the block's RTL only.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import essgi_pkg::*;

  localparam logic [31:0] BLINK_MS = 32'd1000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 4'd8;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 4'd15;

  typedef struct packed {
    logic [9:0]  temp;
    logic [9:0]  setp;
    logic [9:0]  battery;
    logic        mains;
    logic        engine;
    logic        solar;
    logic        spark;
    logic [31:0] now;
  } tick_t;

  typedef struct packed {
    logic       ac;
    logic       dc;
    logic       gas;
    logic       led;
    logic [1:0] pulses;
    logic [3:0] beeps;
    logic [1:0] mode;
    logic [2:0] phase;
  } drive_word_t;

  // Clock, reset and port signals.
  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  tick_t drive_tick = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_ac_heater_on, out_dc_heater_on, out_gas_ignite_on, out_led_on;
  logic [1:0] out_pulse_requests;
  logic [3:0] out_beep_count;
  logic [1:0] out_source_mode;
  logic [2:0] out_gas_phase;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  energy_source_select_gas_ignition dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_temp_level     (drive_tick.temp),
    .in_setpoint_level (drive_tick.setp),
    .in_battery_level  (drive_tick.battery),
    .in_mains_present  (drive_tick.mains),
    .in_engine_running (drive_tick.engine),
    .in_solar_active   (drive_tick.solar),
    .in_spark_present  (drive_tick.spark),
    .in_now_ms         (drive_tick.now),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_ac_heater_on  (out_ac_heater_on),
    .out_dc_heater_on  (out_dc_heater_on),
    .out_gas_ignite_on (out_gas_ignite_on),
    .out_led_on        (out_led_on),
    .out_pulse_requests(out_pulse_requests),
    .out_beep_count    (out_beep_count),
    .out_source_mode   (out_source_mode),
    .out_gas_phase     (out_gas_phase),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // Stimulus and scoreboard storage.
  tick_t       pending_ticks[$];
  drive_word_t predicted_outputs[$];
  int          mismatch_count = 0;
  int          results_seen = 0;
  bit          steady = 1'b0;

  // Random traffic shaping: the intended source, spark and demand odds, and time.
  logic [1:0]  scen_src = MODE_GAS;
  int          spark_pct = 40;
  int          need_pct = 97;
  logic [31:0] clock_ms = '0;

  // Predictor copy of the configuration registers.
  logic [9:0]  cfg_solar_uv  = RST_SOLAR_UV;
  logic [31:0] cfg_prestart  = {1'b0, RST_PRESTART};
  logic [31:0] cfg_spark_chk = {1'b0, RST_SPARK_CHECK};
  logic [31:0] cfg_window    = {1'b0, RST_IGN_WINDOW};
  logic [31:0] cfg_retry     = {1'b0, RST_FAULT_RETRY};
  logic [31:0] cfg_inhibit   = {1'b0, RST_GAS_INHIBIT};
  logic [31:0] cfg_period    = {1'b0, RST_BEEP_PERIOD};
  logic [3:0]  cfg_beeps     = RST_BEEP_PULSES;

  // Predictor copy of the controller state.
  logic [1:0]  cur_mode = MODE_GAS;
  logic [2:0]  seq_phase = PH_IDLE;
  logic [31:0] phase_t0 = '0;
  logic [31:0] fault_end = '0;
  logic [31:0] inhibit_end = '0;
  logic [4:0]  ign_pulses = '0;
  logic        spark_hit = 1'b0;
  logic        inhibit_on = 1'b0;
  logic        beep_ok = 1'b0;
  logic        pulse_ok = 1'b0;
  logic [31:0] last_beep = '0;
  logic [31:0] last_pulse = '0;
  logic        lat_ac = 1'b0, lat_dc = 1'b0, lat_gas = 1'b0, lat_led = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic deadline_hit(input logic [31:0] now, input logic [31:0] end_ms);
    logic [31:0] diff;
    diff = now - end_ms;
    return !diff[31];
  endfunction

  task automatic enter_phase(input logic [2:0] ph, input logic [31:0] now);
    seq_phase = ph;
    phase_t0 = now;
  endtask

  task automatic start_fault_wait(input logic [31:0] now);
    fault_end = now + cfg_retry;
    beep_ok = 1'b0;
    pulse_ok = 1'b0;
    enter_phase(PH_FAULT, now);
  endtask

  // Heater with hold band: on below setpoint, off above, unchanged when equal.
  task automatic heater_band(inout logic lat, input logic need, input logic stop);
    if (need) begin
      lat = 1'b1;
      lat_led = 1'b1;
    end else if (stop) begin
      lat = 1'b0;
      lat_led = 1'b0;
    end
  endtask

  // Advances the controller state by one tick and gives the drive word it produces.
  task automatic predict_controller(input tick_t t, output drive_word_t r);
    logic [1:0]  want_mode;
    logic [1:0]  from_mode;
    logic        need;
    logic        stop;
    logic [31:0] el;
    logic [31:0] blink;
    int          n_pulse;
    logic [3:0]  n_beep;
    need = t.temp < t.setp;
    stop = t.temp > t.setp;
    n_pulse = 0;
    n_beep = '0;

    // Source priority: mains, engine, solar with enough battery, then gas.
    if (t.mains) begin
      want_mode = MODE_AC;
    end else if (t.engine) begin
      want_mode = MODE_DC12;
    end else if (t.solar && t.battery > cfg_solar_uv) begin
      want_mode = MODE_SOLAR;
    end else begin
      want_mode = MODE_GAS;
    end

    // A source change drops every latch; leaving 12 V for gas arms the inhibit.
    if (want_mode != cur_mode) begin
      from_mode = cur_mode;
      cur_mode = want_mode;
      lat_ac = 1'b0;
      lat_dc = 1'b0;
      lat_gas = 1'b0;
      lat_led = 1'b0;
      if (from_mode == MODE_DC12 && want_mode == MODE_GAS) begin
        inhibit_end = t.now + cfg_inhibit;
        inhibit_on = 1'b1;
      end
      if (want_mode != MODE_GAS) begin
        enter_phase(PH_IDLE, t.now);
        spark_hit = 1'b0;
        ign_pulses = '0;
      end
    end

    case (cur_mode)
      MODE_AC: begin
        lat_gas = 1'b0;
        lat_dc = 1'b0;
        heater_band(lat_ac, need, stop);
      end
      MODE_DC12: begin
        lat_gas = 1'b0;
        lat_ac = 1'b0;
        heater_band(lat_dc, need, stop);
      end
      MODE_SOLAR: begin
        lat_gas = 1'b0;
        lat_ac = 1'b0;
        if (t.battery <= cfg_solar_uv) begin
          lat_dc = 1'b0;
          lat_led = 1'b0;
        end else begin
          heater_band(lat_dc, need, stop);
        end
      end
      default: begin
        lat_ac = 1'b0;
        lat_dc = 1'b0;
        el = t.now - phase_t0;
        if (t.mains || t.engine || !need) begin
          // No demand or a better source: gas off and back to idle.
          lat_gas = 1'b0;
          enter_phase(PH_IDLE, t.now);
        end else if (inhibit_on && !deadline_hit(t.now, inhibit_end)) begin
          // Gas blocked after 12 V: the LED blinks with the seconds.
          blink = t.now / BLINK_MS;
          lat_led = blink[0];
          lat_gas = 1'b0;
        end else begin
          inhibit_on = 1'b0;
          case (seq_phase)
            PH_IDLE: begin
              enter_phase(PH_PRESTART, t.now);
            end
            PH_PRESTART: begin
              lat_led = 1'b0;
              lat_gas = 1'b0;
              if (el >= cfg_prestart) begin
                spark_hit = 1'b0;
                lat_gas = 1'b1;
                enter_phase(PH_SPARK, t.now);
              end
            end
            PH_SPARK: begin
              lat_led = 1'b1;
              lat_gas = 1'b1;
              if (t.spark) spark_hit = 1'b1;
              if (el >= cfg_spark_chk) begin
                if (!spark_hit) begin
                  lat_gas = 1'b0;
                  n_pulse = n_pulse + 1;
                  n_beep = NOSPARK_BEEPS;
                  start_fault_wait(t.now);
                end else begin
                  ign_pulses = '0;
                  enter_phase(PH_WINDOW, t.now);
                end
              end
            end
            PH_WINDOW: begin
              lat_led = 1'b1;
              lat_gas = 1'b1;
              if (t.spark && ign_pulses < PULSE_SAT) ign_pulses = ign_pulses + 5'd1;
              if (el >= cfg_window) begin
                if (ign_pulses >= PULSE_FAIL_LIMIT) begin
                  lat_gas = 1'b0;
                  n_pulse = n_pulse + 2;
                  n_beep = NOIGNITE_BEEPS;
                  start_fault_wait(t.now);
                end else begin
                  enter_phase(PH_RUN, t.now);
                end
              end
            end
            PH_RUN: begin
              lat_led = 1'b1;
              lat_gas = 1'b0;
              if (t.spark) begin
                ign_pulses = '0;
                enter_phase(PH_WINDOW, t.now);
              end else if (stop) begin
                enter_phase(PH_IDLE, t.now);
              end
            end
            PH_FAULT: begin
              // Periodic pulse and beep requests, then a retry at the deadline.
              lat_gas = 1'b0;
              if (!pulse_ok || t.now - last_pulse >= PULSE_GAP_MS) begin
                n_pulse = n_pulse + 1;
                last_pulse = t.now;
                pulse_ok = 1'b1;
              end
              if (!beep_ok || t.now - last_beep >= cfg_period) begin
                n_beep = cfg_beeps;
                last_beep = t.now;
                beep_ok = 1'b1;
              end
              if (deadline_hit(t.now, fault_end)) begin
                beep_ok = 1'b0;
                pulse_ok = 1'b0;
                enter_phase(PH_PRESTART, t.now);
              end
            end
            default: begin
              lat_gas = 1'b0;
              enter_phase(PH_IDLE, t.now);
            end
          endcase
        end
      end
    endcase

    r.ac = lat_ac;
    r.dc = lat_dc;
    r.gas = lat_gas;
    r.led = lat_led;
    r.pulses = n_pulse[1:0];
    r.beeps = n_beep;
    r.mode = cur_mode;
    r.phase = seq_phase;
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [3:0] got, input logic [3:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("word %0d: %s is %0d, expected %0d",
                                results_seen, name, got, want));
    end
  endtask

  // Input driver: takes words from the pending queue with random gaps, or none while steady.
  always @(posedge clk) begin : feed
    drive_word_t want;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_controller(drive_tick, want);
        predicted_outputs.push_back(want);
      end
      if (!in_valid || in_ready) begin
        if (pending_ticks.size() != 0 && (steady || $urandom_range(99) >= 37)) begin
          drive_tick <= pending_ticks.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each accepted word with the oldest prediction.
  always @(posedge clk) begin : watch
    drive_word_t seen;
    drive_word_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        seen = {out_ac_heater_on, out_dc_heater_on, out_gas_ignite_on, out_led_on,
                out_pulse_requests, out_beep_count, out_source_mode, out_gas_phase};
        if (predicted_outputs.size() == 0) begin
          report_mismatch($sformatf("word %0d arrived with no tick pending", results_seen));
        end else begin
          want = predicted_outputs.pop_front();
          check_field("ac_heater_on", 4'(seen.ac), 4'(want.ac));
          check_field("dc_heater_on", 4'(seen.dc), 4'(want.dc));
          check_field("gas_ignite_on", 4'(seen.gas), 4'(want.gas));
          check_field("led_on", 4'(seen.led), 4'(want.led));
          check_field("pulse_requests", 4'(seen.pulses), 4'(want.pulses));
          check_field("beep_count", seen.beeps, want.beeps);
          check_field("source_mode", 4'(seen.mode), 4'(want.mode));
          check_field("gas_phase", 4'(seen.phase), 4'(want.phase));
        end
        results_seen++;
      end
      out_ready <= steady || ($urandom_range(99) >= 37);
    end
  end

  // Writes one register; the caller lowers cfg_valid after its last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SOLAR_UV:    cfg_solar_uv = val[9:0];
      REG_PRESTART:    cfg_prestart = {1'b0, val[30:0]};
      REG_SPARK_CHECK: cfg_spark_chk = {1'b0, val[30:0]};
      REG_IGN_WINDOW:  cfg_window = {1'b0, val[30:0]};
      REG_FAULT_RETRY: cfg_retry = {1'b0, val[30:0]};
      REG_GAS_INHIBIT: cfg_inhibit = {1'b0, val[30:0]};
      REG_BEEP_PERIOD: cfg_period = {1'b0, val[30:0]};
      REG_BEEP_PULSES: cfg_beeps = val[3:0];
      default: ;
    endcase
  endtask

  task automatic load_timing(input logic [31:0] uv, input logic [31:0] pre,
                             input logic [31:0] spk, input logic [31:0] win,
                             input logic [31:0] retry, input logic [31:0] inh,
                             input logic [31:0] period, input logic [31:0] beeps);
    write_reg(REG_SOLAR_UV, uv);
    write_reg(REG_PRESTART, pre);
    write_reg(REG_SPARK_CHECK, spk);
    write_reg(REG_IGN_WINDOW, win);
    write_reg(REG_FAULT_RETRY, retry);
    write_reg(REG_GAS_INHIBIT, inh);
    write_reg(REG_BEEP_PERIOD, period);
    write_reg(REG_BEEP_PULSES, beeps);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_tick(input logic [9:0] temp, input logic [9:0] setp,
                           input logic [9:0] battery, input logic mains, input logic engine,
                           input logic solar, input logic spark, input logic [31:0] now);
    tick_t t;
    t.temp = temp;
    t.setp = setp;
    t.battery = battery;
    t.mains = mains;
    t.engine = engine;
    t.solar = solar;
    t.spark = spark;
    t.now = now;
    pending_ticks.push_back(t);
  endtask

  // Random ticks in runs: a source scenario holds for a while, time moves forward
  // in small steps with an occasional jump, and the spark odds follow the scenario.
  task automatic queue_random(input int count, input logic [31:0] step_max);
    tick_t t;
    int    roll;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 5) begin
        roll = $urandom_range(99);
        scen_src = roll < 55 ? MODE_GAS : roll < 70 ? MODE_AC :
                   roll < 85 ? MODE_DC12 : MODE_SOLAR;
        roll = $urandom_range(2);
        spark_pct = roll == 0 ? 3 : roll == 1 ? 40 : 95;
        need_pct = $urandom_range(1) ? 97 : 70;
      end
      t.mains = (scen_src == MODE_AC) ^ ($urandom_range(99) < 2);
      t.engine = (scen_src == MODE_DC12) ^ ($urandom_range(99) < 2);
      t.solar = (scen_src == MODE_SOLAR) || ($urandom_range(99) < 3);
      if (scen_src == MODE_SOLAR && $urandom_range(9) != 0) begin
        t.battery = 10'($urandom_range(1023, cfg_solar_uv));
      end else begin
        t.battery = 10'($urandom_range(1023));
      end
      t.spark = $urandom_range(99) < spark_pct;
      roll = $urandom_range(99);
      if (roll < need_pct) begin
        t.setp = 10'($urandom_range(1023, 1));
        t.temp = 10'($urandom_range(t.setp - 1, 0));
      end else if (roll[0]) begin
        t.setp = 10'($urandom_range(1023));
        t.temp = t.setp;
      end else begin
        t.temp = 10'($urandom_range(1023, 1));
        t.setp = 10'($urandom_range(t.temp - 1, 0));
      end
      if ($urandom_range(99) == 0) begin
        clock_ms = $urandom;
      end else begin
        clock_ms = clock_ms + $urandom_range(step_max, 0);
      end
      t.now = clock_ms;
      pending_ticks.push_back(t);
    end
  endtask

  // Waits until every queued word went in and every prediction was matched.
  task automatic settle();
    while (pending_ticks.size() != 0 || in_valid || predicted_outputs.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // Run control: reset, directed sequence, then randomized phases per setting.
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: full gas sequence, every source, hold band, inhibit and fault alarms.
    push_tick(10'd0, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
    push_tick(10'd0, 10'd1023, 10'd1023, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
    push_tick(10'd0, 10'd1023, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd2000);
    push_tick(10'd0, 10'd1023, 10'd0, 1'b0, 1'b0, 1'b0, 1'b1, 32'd2500);
    push_tick(10'd0, 10'd1023, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd5000);
    push_tick(10'd1023, 10'd0, 10'd1023, 1'b1, 1'b0, 1'b0, 1'b0, 32'd5100);
    push_tick(10'd0, 10'd1023, 10'd1023, 1'b1, 1'b0, 1'b0, 1'b0, 32'd5200);
    push_tick(10'd1023, 10'd1023, 10'd0, 1'b1, 1'b0, 1'b0, 1'b0, 32'd5300);
    push_tick(10'd0, 10'd1023, 10'd0, 1'b1, 1'b1, 1'b1, 1'b1, 32'd5400);
    push_tick(10'd0, 10'd1023, 10'd0, 1'b0, 1'b1, 1'b0, 1'b0, 32'd6000);
    push_tick(10'd0, 10'd1023, 10'd1023, 1'b0, 1'b0, 1'b1, 1'b0, 32'd7000);
    push_tick(10'd0, 10'd1023, 10'd0, 1'b0, 1'b1, 1'b1, 1'b1, 32'd10000);
    push_tick(10'd0, 10'd1023, 10'd512, 1'b0, 1'b0, 1'b1, 1'b0, 32'd10000);
    push_tick(10'd0, 10'd1023, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd11000);
    push_tick(10'd0, 10'd1023, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd910000);
    push_tick(10'd0, 10'd1023, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd912000);
    push_tick(10'd0, 10'd1023, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd915000);
    push_tick(10'd0, 10'd1023, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd915100);
    push_tick(10'd0, 10'd1023, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd915600);
    push_tick(10'd0, 10'd1023, 10'd0, 1'b0, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF);
    push_tick(10'd0, 10'd1023, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd1515000);
    push_tick(10'd1023, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd1515001);
    settle();

    // Short timings on a millisecond scale.
    clock_ms = 32'd2000000;
    load_timing(32'd512, 32'd5, 32'd10, 32'd60, 32'd60, 32'd30, 32'd4, 32'd3);
    queue_random(130, 32'd3);
    settle();

    // All timings zero, most beeps, and both sides without gaps.
    steady = 1'b1;
    load_timing(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd15);
    queue_random(100, 32'd2);
    settle();
    steady = 1'b0;

    // Largest timings (bit 31 written and dropped), solar never allowed, no beeps.
    load_timing(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    queue_random(70, 32'h4000_0000);
    settle();

    // Coarse timings that let fault waits repeat pulse and beep requests, over the wrap.
    clock_ms = 32'hFFFF_F000;
    load_timing(32'd300, 32'd300, 32'd400, 32'd4500, 32'd5000, 32'd2000, 32'd700, 32'd7);
    queue_random(150, 32'd250);
    settle();

    // Random timings; writes to spare indexes must change nothing.
    write_reg(REG_SPARE_LO, $urandom);
    write_reg(REG_SPARE_HI, $urandom);
    load_timing($urandom, $urandom_range(3000), $urandom_range(4000), $urandom_range(40000),
                $urandom_range(20000), $urandom_range(20000), $urandom_range(3000),
                $urandom);
    queue_random(150, 32'd2000);
    settle();

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire

/* energy_source_select_gas_ignition.f */
design/essgi_pkg.sv
design/energy_source_select_gas_ignition.sv
tb/sv/tb.sv
